@@ src/txrv_pkg.sv @@
package txrv_pkg;

    // sizes of the block
    localparam int CHAIN_COUNT = 2;
    localparam int TABLE_DEPTH = 16;
    localparam int CHAIN_W     = 1;
    localparam int IDX_W       = 4;
    localparam int ADDR_W      = CHAIN_W + IDX_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int POWER_W     = 8;
    localparam int SIZE_W      = 5;
    localparam int FREQ_W      = 32;
    localparam int PRE_W       = 16;
    localparam int CHAIN_REGS  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // minimum preamble lengths
    localparam logic [PRE_W-1:0] CHIRP_MIN_PRE = PRE_W'(6);
    localparam logic [PRE_W-1:0] FSK_MIN_PRE   = PRE_W'(3);

    // modulation codes
    localparam logic [1:0] MOD_CHIRP = 2'd0;
    localparam logic [1:0] MOD_FSK   = 2'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TBL_SIZE0  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TBL_SIZE1  = 3'd7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_GPS_OFF   = 3'd1,
        ST_BAD_MODE  = 3'd2,
        ST_CHAIN_OFF = 3'd3,
        ST_BAD_MOD   = 3'd4,
        ST_BAD_FREQ  = 3'd5,
        ST_SUBST     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_IMMEDIATE   = 2'd0,
        MODE_TIMESTAMPED = 2'd1,
        MODE_GPS         = 2'd2,
        MODE_UNKNOWN     = 2'd3
    } t_tx_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_FLO,
        S_FHI,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

endpackage

@@ src/txrv_ram.sv @@
module txrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tx_request_validator.sv @@
// Transmit request validator. A request is taken only while the block is idle and
// is answered by exactly one result. A load item (command 1) writes one power table
// entry and goes straight to the finishing step. A transmit request walks through
// mode, chain and modulation checks, two frequency window compares on one shared
// 32-bit comparator, then a pipelined walk of the chain's power table through a RAM
// with one write port and one registered read port, one entry per cycle, and a
// finishing step. A table holds at most 16 entries; a size of zero still reads entry
// 0 but selects no entry. The table reads as zero after reset without a clearing
// pass: each entry has a written flag that reset clears.
module tx_request_validator
    import txrv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_command,
    input  logic [1:0]              i_tx_mode,
    input  logic [CHAIN_W-1:0]      i_radio_chain,
    input  logic [1:0]              i_modulation,
    input  logic [PRE_W-1:0]        i_preamble_len,
    input  logic [FREQ_W-1:0]       i_freq_hz,
    input  logic signed [POWER_W-1:0] i_req_power,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [POWER_W-1:0] i_entry_power,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_status,
    output logic signed [POWER_W-1:0] o_out_power,
    output logic [PRE_W-1:0]        o_out_preamble,
    output logic [IDX_W-1:0]        o_gain_index
);

    // configuration registers
    logic [CHAIN_REGS-1:0]   r_chain_en;
    logic [POWER_W-1:0]      r_gain;
    logic [FREQ_W-1:0]       r_freq_min [CHAIN_REGS];
    logic [FREQ_W-1:0]       r_freq_max [CHAIN_REGS];
    logic [SIZE_W-1:0]       r_tbl_size [CHAIN_REGS];

    // sequencer and working registers
    t_state                  r_state, n_state;
    t_tx_mode                r_mode, n_mode;
    logic [CHAIN_W-1:0]      r_chain, n_chain;
    logic [1:0]              r_modu, n_modu;
    logic [PRE_W-1:0]        r_pre, n_pre;
    logic [FREQ_W-1:0]       r_freq, n_freq;
    logic [POWER_W-1:0]      r_power, n_power;
    t_status                 r_status, n_status;
    logic [IDX_W-1:0]        r_gidx, n_gidx;
    logic                    r_scan, n_scan;
    logic [SIZE_W-1:0]       r_size, n_size;
    logic [IDX_W-1:0]        r_last, n_last;
    logic [IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                    r_cmp_pend, n_cmp_pend;
    logic                    r_found, n_found;
    logic [POWER_W-1:0]      r_best, n_best;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [POWER_W-1:0]      r_best_pow, n_best_pow;
    logic [POWER_W-1:0]      r_entry0, n_entry0;

    // output registers
    logic                    r_out_valid, n_out_valid;
    t_status                 r_o_status, n_o_status;
    logic [POWER_W-1:0]      r_o_power, n_o_power;
    logic [PRE_W-1:0]        r_o_pre, n_o_pre;
    logic [IDX_W-1:0]        r_o_gidx, n_o_gidx;

    // table storage
    logic [RAM_DEPTH-1:0]    r_ent_vld;
    logic                    r_rd_vld;
    logic                    tbl_we;
    logic [ADDR_W-1:0]       tbl_waddr;
    logic                    tbl_re;
    logic [ADDR_W-1:0]       tbl_raddr;
    logic [POWER_W-1:0]      tbl_rdata;
    logic [POWER_W-1:0]      scan_data;

    // shared units
    logic [POWER_W-1:0]      sub_b;
    logic [POWER_W:0]        sub_res;
    logic [FREQ_W-1:0]       cmp_a, cmp_b;
    logic                    cmp_lt;

    logic                    in_acc;
    logic                    out_free;
    logic                    do_cmp;
    logic                    qualify;
    logic [SIZE_W-1:0]       size_clamp;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_en <= '0;
            r_gain     <= '0;
            for (int c = 0; c < CHAIN_REGS; c++) begin
                r_freq_min[c] <= '0;
                r_freq_max[c] <= '1;
                r_tbl_size[c] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHAIN_EN:  r_chain_en    <= i_cfg_data[CHAIN_REGS-1:0];
                REG_ANT_GAIN:  r_gain        <= i_cfg_data[POWER_W-1:0];
                REG_FREQ_MIN0: r_freq_min[0] <= i_cfg_data[FREQ_W-1:0];
                REG_FREQ_MAX0: r_freq_max[0] <= i_cfg_data[FREQ_W-1:0];
                REG_FREQ_MIN1: r_freq_min[1] <= i_cfg_data[FREQ_W-1:0];
                REG_FREQ_MAX1: r_freq_max[1] <= i_cfg_data[FREQ_W-1:0];
                REG_TBL_SIZE0: r_tbl_size[0] <= i_cfg_data[SIZE_W-1:0];
                REG_TBL_SIZE1: r_tbl_size[1] <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // table write from a load request
    assign tbl_we = in_acc && i_command
                    && (int'(i_radio_chain) < CHAIN_COUNT)
                    && (int'(i_entry_index) < TABLE_DEPTH);
    assign tbl_waddr = {i_radio_chain, i_entry_index};
    assign tbl_re    = (r_state == S_SCAN);
    assign tbl_raddr = {r_chain, r_rd_idx};

    txrv_ram #(
        .WIDTH (POWER_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_entry_power),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // written flags, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (tbl_we) begin
            r_ent_vld[tbl_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_re) begin
            r_rd_vld <= r_ent_vld[tbl_raddr];
        end
    end

    assign scan_data = r_rd_vld ? tbl_rdata : '0;

    // shared subtractor: gain correction, then power minus table entry
    assign sub_b   = (r_state == S_GAIN) ? r_gain : scan_data;
    assign sub_res = {r_power[POWER_W-1], r_power} - {sub_b[POWER_W-1], sub_b};

    // shared comparator for the frequency window
    always_comb begin
        if (r_state == S_FLO) begin
            cmp_a = r_freq;
            cmp_b = r_freq_min[r_chain];
        end else begin
            cmp_a = r_freq_max[r_chain];
            cmp_b = r_freq;
        end
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // walk bookkeeping
    assign do_cmp  = ((r_state == S_SCAN) && r_cmp_pend) || (r_state == S_LAST);
    assign qualify = ({1'b0, r_cmp_idx} < r_size) && !sub_res[POWER_W];
    assign size_clamp = (r_tbl_size[r_chain] > SIZE_W'(TABLE_DEPTH))
                        ? SIZE_W'(TABLE_DEPTH) : r_tbl_size[r_chain];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_command ? S_DONE : S_GAIN;
                end
            end
            S_GAIN: begin
                if (r_mode == MODE_GPS || r_mode == MODE_UNKNOWN
                    || int'(r_chain) >= CHAIN_COUNT || !r_chain_en[r_chain]
                    || (r_modu != MOD_CHIRP && r_modu != MOD_FSK)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FLO;
                end
            end
            S_FLO: begin
                n_state = cmp_lt ? S_DONE : S_FHI;
            end
            S_FHI: begin
                n_state = cmp_lt ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (r_rd_idx == r_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mode      = r_mode;
        n_chain     = r_chain;
        n_modu      = r_modu;
        n_pre       = r_pre;
        n_freq      = r_freq;
        n_power     = r_power;
        n_status    = r_status;
        n_gidx      = r_gidx;
        n_scan      = r_scan;
        n_size      = r_size;
        n_last      = r_last;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_pend  = r_cmp_pend;
        n_found     = r_found;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_pow  = r_best_pow;
        n_entry0    = r_entry0;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_power   = r_o_power;
        n_o_pre     = r_o_pre;
        n_o_gidx    = r_o_gidx;

        unique case (r_state)
            S_IDLE: begin
                // capture the request
                if (in_acc) begin
                    n_mode   = t_tx_mode'(i_tx_mode);
                    n_chain  = i_radio_chain;
                    n_modu   = i_modulation;
                    n_freq   = i_freq_hz;
                    n_status = ST_OK;
                    n_scan   = 1'b0;
                    if (i_command) begin
                        n_power = i_entry_power;
                        n_pre   = '0;
                        n_gidx  = i_entry_index;
                    end else begin
                        n_power = i_req_power;
                        n_pre   = i_preamble_len;
                        n_gidx  = '0;
                    end
                end
            end
            S_GAIN: begin
                // mode, chain and modulation checks, gain correction, preamble clamp
                priority if (r_mode == MODE_GPS) begin
                    n_status = ST_GPS_OFF;
                end else if (r_mode == MODE_UNKNOWN) begin
                    n_status = ST_BAD_MODE;
                end else if (int'(r_chain) >= CHAIN_COUNT || !r_chain_en[r_chain]) begin
                    n_status = ST_CHAIN_OFF;
                end else begin
                    n_power = sub_res[POWER_W-1:0];
                    priority if (r_modu == MOD_CHIRP) begin
                        if (r_pre < CHIRP_MIN_PRE) begin
                            n_pre = CHIRP_MIN_PRE;
                        end
                    end else if (r_modu == MOD_FSK) begin
                        if (r_pre < FSK_MIN_PRE) begin
                            n_pre = FSK_MIN_PRE;
                        end
                    end else begin
                        n_status = ST_BAD_MOD;
                    end
                end
            end
            S_FLO: begin
                if (cmp_lt) begin
                    n_status = ST_BAD_FREQ;
                end
            end
            S_FHI: begin
                // upper frequency bound; if ok, set up the table walk
                if (cmp_lt) begin
                    n_status = ST_BAD_FREQ;
                end else begin
                    n_scan     = 1'b1;
                    n_size     = size_clamp;
                    n_last     = (size_clamp == '0) ? '0 : IDX_W'(size_clamp - 1'b1);
                    n_rd_idx   = '0;
                    n_cmp_pend = 1'b0;
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_best_idx = '0;
                    n_best_pow = '0;
                    n_entry0   = '0;
                end
            end
            S_SCAN: begin
                n_cmp_pend = 1'b1;
                n_cmp_idx  = r_rd_idx;
                if (r_rd_idx != r_last) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_cmp_pend = 1'b0;
            end
            S_DONE: begin
                // resolve and move into the output register
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_pre     = r_pre;
                    if (r_scan) begin
                        if (r_found && r_best == '0) begin
                            n_o_status = ST_OK;
                            n_o_power  = r_power;
                            n_o_gidx   = r_best_idx;
                        end else begin
                            n_o_status = ST_SUBST;
                            n_o_power  = r_found ? r_best_pow : r_entry0;
                            n_o_gidx   = r_found ? r_best_idx : '0;
                        end
                    end else begin
                        n_o_status = r_status;
                        n_o_power  = r_power;
                        n_o_gidx   = r_gidx;
                    end
                end
            end
        endcase

        // closest entry not above the corrected power, lowest index on ties
        if (do_cmp) begin
            if (r_cmp_idx == '0) begin
                n_entry0 = scan_data;
            end
            if (qualify && (!r_found || sub_res[POWER_W-1:0] < r_best)) begin
                n_found    = 1'b1;
                n_best     = sub_res[POWER_W-1:0];
                n_best_idx = r_cmp_idx;
                n_best_pow = scan_data;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_chain    <= n_chain;
        r_modu     <= n_modu;
        r_pre      <= n_pre;
        r_freq     <= n_freq;
        r_power    <= n_power;
        r_status   <= n_status;
        r_gidx     <= n_gidx;
        r_scan     <= n_scan;
        r_size     <= n_size;
        r_last     <= n_last;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_pend <= n_cmp_pend;
        r_found    <= n_found;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_pow <= n_best_pow;
        r_entry0   <= n_entry0;
        r_o_status <= n_o_status;
        r_o_power  <= n_o_power;
        r_o_pre    <= n_o_pre;
        r_o_gidx   <= n_o_gidx;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_out_power    = r_o_power;
    assign o_out_preamble = r_o_pre;
    assign o_gain_index   = r_o_gidx;

    // a new result appears only out of the finishing step
    a_result_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE
    ) else $error("result appeared outside the finishing step");

    // the walk never reads past the last table entry of the chain
    a_walk_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_rd_idx <= r_last
    ) else $error("table walk past last entry");

    // a chosen entry lies inside the chain's table
    a_best_in_table: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_scan && r_found) |-> {1'b0, r_best_idx} < r_size
    ) else $error("chosen entry outside table");

endmodule
